FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the frustum cull core.
// Bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define VFC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");
`define VFC_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("%m: reset check failed");
`else
`define VFC_ASSERT(lbl, clk, rstn, prop)
`define VFC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/vfc_pkg.sv
// Shared types and constants for the frustum cull core.
// No dependencies.
`timescale 1ns / 1ps
package vfc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int NUM_CORNERS = 8;
  localparam int NUM_REGS    = 4;

  localparam int COORD_W  = 24;
  localparam int RADIUS_W = 23;
  localparam int ENTRY_W  = 16;
  localparam int COEF_W   = ENTRY_W + 1;
  localparam int REG_W    = 64;
  localparam int PROD_W   = COEF_W + COORD_W;
  localparam int DIST_W   = 45;
  localparam int PLANE_W  = $clog2(NUM_PLANES);
  localparam int CORNER_W = $clog2(NUM_CORNERS);
  localparam int REGIDX_W = $clog2(NUM_REGS);

  localparam logic [1:0] FUNC_POINT  = 2'd0;
  localparam logic [1:0] FUNC_BOX    = 2'd1;
  localparam logic [1:0] FUNC_SPHERE = 2'd2;

  localparam logic [PLANE_W-1:0]  LAST_PLANE  = PLANE_W'(NUM_PLANES - 1);
  localparam logic [CORNER_W-1:0] LAST_CORNER = CORNER_W'(NUM_CORNERS - 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef struct packed {
    logic vld;
    logic plane_end;
    logic last;
  } tag_t;

endpackage

FILE: rtl/core/vfc_dot_unit.sv
// Shared two-stage plane dot-product unit: d = n.p + w*16.
// Depends on vfc_pkg.
`timescale 1ns / 1ps
module vfc_dot_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  vfc_pkg::tag_t   in_tag,
  input  vfc_pkg::coef_t  nx,
  input  vfc_pkg::coef_t  ny,
  input  vfc_pkg::coef_t  nz,
  input  vfc_pkg::coef_t  nw,
  input  vfc_pkg::coord_t px,
  input  vfc_pkg::coord_t py,
  input  vfc_pkg::coord_t pz,
  output vfc_pkg::tag_t   out_tag,
  output vfc_pkg::dist_t  out_d
);
  import vfc_pkg::*;

  logic signed [PROD_W-1:0] px_prod_r, py_prod_r, pz_prod_r;
  logic signed [COEF_W+3:0] w16_r;
  tag_t                     tag1_r, tag2_r;
  dist_t                    d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
    end else begin
      tag1_r <= in_tag;
      tag2_r <= tag1_r;
    end
  end

  always_ff @(posedge clk) begin
    px_prod_r <= PROD_W'(nx * px);
    py_prod_r <= PROD_W'(ny * py);
    pz_prod_r <= PROD_W'(nz * pz);
    w16_r     <= {nw, 4'b0000};
    d_r       <= DIST_W'(px_prod_r) + DIST_W'(py_prod_r) + DIST_W'(pz_prod_r)
               + DIST_W'(w16_r);
  end

  assign out_tag = tag2_r;
  assign out_d   = d_r;

endmodule

FILE: rtl/core/view_frustum_cull_test_core.sv
// View frustum cull test core: point, box and sphere tests against six planes.
// Depends on vfc_pkg, vfc_dot_unit and assert_macros.svh.
//
// Usage: write the four matrix columns through cfg_wr_en/cfg_index/cfg_wdata
// while the core is idle; reset loads the identity matrix. Planes are formed
// on the fly from the columns. A beat on the in_ channel (in_valid high,
// in_stall low) carries a test code and operands; one beat on the out_
// channel returns the visibility bit.
// Every plane/corner pair goes through one shared dot-product unit, one pair
// per cycle, through its registered products and registered sum. Point and
// sphere tests take 6 pairs and a box test takes 48 pairs. An unused test
// code answers culled in the cycle after accept.
// One item is in flight at a time: in_stall stays high from accept until
// the result beat is taken. When the receiver stalls, out_valid and
// out_visible hold. Synchronous active-low reset clears all control state.
`timescale 1ns / 1ps
module view_frustum_cull_test_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [vfc_pkg::REGIDX_W-1:0]   cfg_index,
  input  logic [vfc_pkg::REG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic signed [23:0]             in_ax,
  input  logic signed [23:0]             in_ay,
  input  logic signed [23:0]             in_az,
  input  logic signed [23:0]             in_bx,
  input  logic signed [23:0]             in_by_coord,
  input  logic signed [23:0]             in_bz,
  input  logic [vfc_pkg::RADIUS_W-1:0]   in_radius,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_visible
);
  import vfc_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_OUT} state_t;

  state_t                     state_r, state_nxt;
  logic [NUM_REGS-1:0][REG_W-1:0] matrix_r;
  logic [1:0]                 func_r;
  coord_t                     ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic [RADIUS_W-1:0]        radius_r;
  logic [PLANE_W-1:0]         plane_r, plane_nxt;
  logic [CORNER_W-1:0]        corner_r, corner_nxt;
  logic                       vis_r, vis_nxt;
  logic                       any_in_r, any_in_nxt;
  logic                       decided_r, decided_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_visible_r, out_visible_nxt;

  logic                       accept;
  tag_t                       iss_tag, res_tag;
  coef_t                      coef [4];
  coord_t                     cx, cy, cz;
  dist_t                      res_d, abs_d, rad_d;
  logic                       pos;
  logic [1:0]                 axis;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);

  // plane 2a is col3 - col a, plane 2a+1 is col3 + col a
  assign axis = 2'(plane_r[PLANE_W-1:1]);
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (plane_r[0]) begin
        coef[c] = COEF_W'($signed(matrix_r[3][c*ENTRY_W +: ENTRY_W]))
                + COEF_W'($signed(matrix_r[axis][c*ENTRY_W +: ENTRY_W]));
      end else begin
        coef[c] = COEF_W'($signed(matrix_r[3][c*ENTRY_W +: ENTRY_W]))
                - COEF_W'($signed(matrix_r[axis][c*ENTRY_W +: ENTRY_W]));
      end
    end
  end

  assign cx = corner_r[2] ? bx_r : ax_r;
  assign cy = corner_r[1] ? by_r : ay_r;
  assign cz = corner_r[0] ? bz_r : az_r;

  always_comb begin
    iss_tag.vld       = (state_r == S_RUN);
    iss_tag.plane_end = (func_r != FUNC_BOX) || (corner_r == LAST_CORNER);
    iss_tag.last      = iss_tag.plane_end && (plane_r == LAST_PLANE);
  end

  vfc_dot_unit u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tag  (iss_tag),
    .nx      (coef[0]),
    .ny      (coef[1]),
    .nz      (coef[2]),
    .nw      (coef[3]),
    .px      (cx),
    .py      (cy),
    .pz      (cz),
    .out_tag (res_tag),
    .out_d   (res_d)
  );

  assign pos   = (res_d > 0);
  assign abs_d = res_d[DIST_W-1] ? -res_d : res_d;
  assign rad_d = dist_t'({{(DIST_W-RADIUS_W-14){1'b0}}, radius_r, 14'b0});

  always_comb begin
    state_nxt       = state_r;
    plane_nxt       = plane_r;
    corner_nxt      = corner_r;
    vis_nxt         = vis_r;
    any_in_nxt      = any_in_r;
    decided_nxt     = decided_r;
    out_valid_nxt   = out_valid_r;
    out_visible_nxt = out_visible_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          plane_nxt   = '0;
          corner_nxt  = '0;
          vis_nxt     = 1'b1;
          any_in_nxt  = 1'b0;
          decided_nxt = 1'b0;
          if (in_func == FUNC_POINT || in_func == FUNC_BOX || in_func == FUNC_SPHERE) begin
            state_nxt = S_RUN;
          end else begin
            out_valid_nxt   = 1'b1;
            out_visible_nxt = 1'b0;
            state_nxt       = S_OUT;
          end
        end
      end
      S_RUN: begin
        if (iss_tag.last) begin
          state_nxt = S_WAIT;
        end else if (iss_tag.plane_end) begin
          plane_nxt  = plane_r + 1'b1;
          corner_nxt = '0;
        end else begin
          corner_nxt = corner_r + 1'b1;
        end
      end
      S_WAIT: begin
      end
      S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (res_tag.vld) begin
      case (func_r)
        FUNC_POINT: begin
          if (!pos) vis_nxt = 1'b0;
        end
        FUNC_BOX: begin
          if (res_tag.plane_end) begin
            if (!(any_in_r || pos)) vis_nxt = 1'b0;
            any_in_nxt = 1'b0;
          end else begin
            any_in_nxt = any_in_r || pos;
          end
        end
        FUNC_SPHERE: begin
          if (!decided_r) begin
            if (res_d < -rad_d) begin
              vis_nxt     = 1'b0;
              decided_nxt = 1'b1;
            end else if (abs_d < rad_d) begin
              vis_nxt     = 1'b1;
              decided_nxt = 1'b1;
            end
          end
        end
        default: vis_nxt = 1'b0;
      endcase
      if (res_tag.last) begin
        out_valid_nxt   = 1'b1;
        out_visible_nxt = vis_nxt;
        state_nxt       = S_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      plane_r       <= '0;
      corner_r      <= '0;
      vis_r         <= 1'b0;
      any_in_r      <= 1'b0;
      decided_r     <= 1'b0;
      out_valid_r   <= 1'b0;
      out_visible_r <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      plane_r       <= plane_nxt;
      corner_r      <= corner_nxt;
      vis_r         <= vis_nxt;
      any_in_r      <= any_in_nxt;
      decided_r     <= decided_nxt;
      out_valid_r   <= out_valid_nxt;
      out_visible_r <= out_visible_nxt;
    end
  end

  // matrix columns: identity at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      matrix_r[0] <= REG_W'(64'h0000_0000_0000_4000);
      matrix_r[1] <= REG_W'(64'h0000_0000_4000_0000);
      matrix_r[2] <= REG_W'(64'h0000_4000_0000_0000);
      matrix_r[3] <= REG_W'(64'h4000_0000_0000_0000);
    end else if (cfg_wr_en) begin
      matrix_r[cfg_index] <= cfg_wdata;
    end
  end

  // hold operands of the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r   <= in_func;
      ax_r     <= in_ax;
      ay_r     <= in_ay;
      az_r     <= in_az;
      bx_r     <= in_bx;
      by_r     <= in_by_coord;
      bz_r     <= in_bz;
      radius_r <= in_radius;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_visible = out_visible_r;

  `VFC_ASSERT(a_busy_after_accept, clk, rst_n, accept |=> in_stall)
  `VFC_ASSERT(a_plane_in_range, clk, rst_n, plane_r <= LAST_PLANE)
  `VFC_ASSERT(a_result_while_busy, clk, rst_n,
              res_tag.vld |-> (state_r == S_RUN || state_r == S_WAIT))
  `VFC_ASSERT(a_out_blocks_input, clk, rst_n, out_valid_r |-> in_stall)
  `VFC_ASSERT_RST(a_reset_clears_out, clk, !rst_n |=> !out_valid_r)

endmodule
